/* design/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, register map, controller states, operations and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // payload widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 31;
   localparam int CAP_W   = 5;

   // register port
   localparam int              CSR_DATA_W       = 32;
   localparam int              CSR_ADDR_W       = 3;
   localparam logic            CSR_IDX_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET       = 5'd16;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_READ,
      ST_COMMIT
   } state_type;

   // what a transaction does to the table
   typedef enum logic [2:0] {
      OP_GET_MISS,
      OP_GET_HIT,
      OP_SET_HIT,
      OP_FILL,
      OP_EVICT
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic   load;     // capture the request
      logic   capture;  // register the lookup result
      logic   read;     // read phase of the memories
      logic   commit;   // table update and response
      op_type op;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_set;
      logic hit;
      logic can_fill;
   } status_type;

endpackage

/* design/lkvc_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lkvc_ctrl.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences one transaction through match, read and commit, and picks the
// operation from the registered lookup status.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lkvc_pkg::status_type status,
   output lkvc_pkg::cmd_type    cmd
);

   lkvc_pkg::state_type state_ff, state_in;
   lkvc_pkg::op_type    op;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // operation from lookup status
   always_comb begin
      if (status.hit) begin
         op = status.is_set ? lkvc_pkg::OP_SET_HIT : lkvc_pkg::OP_GET_HIT;
      end else if (!status.is_set) begin
         op = lkvc_pkg::OP_GET_MISS;
      end else if (status.can_fill) begin
         op = lkvc_pkg::OP_FILL;
      end else begin
         op = lkvc_pkg::OP_EVICT;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.capture = 1'b0;
      cmd.read    = 1'b0;
      cmd.commit  = 1'b0;
      cmd.op      = op;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = lkvc_pkg::ST_MATCH;
            end
         end
         lkvc_pkg::ST_MATCH: begin
            cmd.capture = 1'b1;
            state_in    = lkvc_pkg::ST_READ;
         end
         lkvc_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = lkvc_pkg::ST_COMMIT;
         end
         lkvc_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != lkvc_pkg::ST_IDLE);

endmodule

/* design/lkvc_datapath.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Key match array with valid and recency flops, value and key RAMs, and the
// response registers.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lkvc_pkg::cmd_type                  cmd,
   output lkvc_pkg::status_type               status,
   input  logic [lkvc_pkg::CAP_W-1:0]         capacity,
   input  logic                               req_type,
   input  logic signed [lkvc_pkg::KEY_W-1:0]  req_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]       req_value,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [lkvc_pkg::VALUE_W-1:0]       rsp_read_value,
   output logic                               rsp_evicted,
   output logic signed [lkvc_pkg::KEY_W-1:0]  rsp_evicted_key
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

   // one-hot to index, an OR over independent bits
   function automatic logic [IDX_W-1:0] oh_to_idx(input logic [ENTRIES-1:0] oh);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (oh[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // request registers
   logic                              req_type_ff;
   logic signed [lkvc_pkg::KEY_W-1:0] key_ff;
   logic [lkvc_pkg::VALUE_W-1:0]      value_ff;

   // table state
   logic [ENTRIES-1:0]                valid_ff;
   logic [IDX_W-1:0]                  rank_ff [ENTRIES];
   logic signed [lkvc_pkg::KEY_W-1:0] cam_key_ff [ENTRIES];
   logic [OCC_W-1:0]                  occ_ff;

   // lookup result registers
   logic               hit_ff;
   logic               can_fill_ff;
   logic [ENTRIES-1:0] found_oh_ff, oldest_oh_ff, free_oh_ff;
   logic [IDX_W-1:0]   found_idx_ff, oldest_idx_ff, free_idx_ff;
   logic [IDX_W-1:0]   found_rank_ff;

   // lookup logic
   logic [ENTRIES-1:0] match_vec, oldest_vec, vacant, free_oh;
   logic [IDX_W-1:0]   found_rank;
   logic [OCC_W-1:0]   occ_less;
   logic [CMP_W-1:0]   cap_ext, cap_eff;

   // commit logic
   logic [ENTRIES-1:0] tgt_oh;
   logic [IDX_W-1:0]   old_rank;
   logic               age_all, touch;
   logic               val_wr_en, key_wr_en, val_rd_en, key_rd_en;
   logic [IDX_W-1:0]   val_wr_addr, key_wr_addr;
   logic [lkvc_pkg::VALUE_W-1:0]      val_rdata;
   logic [lkvc_pkg::KEY_W-1:0]        key_rdata;

   // response registers
   logic                              rsp_valid_ff;
   logic                              rsp_hit_ff;
   logic [lkvc_pkg::VALUE_W-1:0]      rsp_read_value_ff;
   logic                              rsp_evicted_ff;
   logic signed [lkvc_pkg::KEY_W-1:0] rsp_evicted_key_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_type;
         key_ff      <= req_key;
         value_ff    <= req_value;
      end
   end

   // parallel key compare, oldest entry and lowest free slot
   always_comb begin
      occ_less   = occ_ff - OCC_W'(1);
      found_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i]  = valid_ff[i] && (cam_key_ff[i] == key_ff);
         oldest_vec[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_less);
         found_rank    = found_rank | (match_vec[i] ? rank_ff[i] : '0);
      end
      vacant  = ~valid_ff;
      free_oh = vacant & (~vacant + ENTRIES'(1));
   end

   // capacity clamped to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // lookup result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_ff        <= |match_vec;
         can_fill_ff   <= CMP_W'(occ_ff) < cap_eff;
         found_oh_ff   <= match_vec;
         oldest_oh_ff  <= oldest_vec;
         free_oh_ff    <= free_oh;
         found_idx_ff  <= oh_to_idx(match_vec);
         oldest_idx_ff <= oh_to_idx(oldest_vec);
         free_idx_ff   <= oh_to_idx(free_oh);
         found_rank_ff <= found_rank;
      end
   end

   assign status.is_set   = req_type_ff;
   assign status.hit      = hit_ff;
   assign status.can_fill = can_fill_ff;

   // target entry and the rank it leaves behind
   always_comb begin
      tgt_oh   = '0;
      old_rank = found_rank_ff;
      age_all  = 1'b0;
      touch    = 1'b0;
      case (cmd.op)
         lkvc_pkg::OP_GET_HIT, lkvc_pkg::OP_SET_HIT: begin
            tgt_oh = found_oh_ff;
            touch  = 1'b1;
         end
         lkvc_pkg::OP_FILL: begin
            tgt_oh  = free_oh_ff;
            age_all = 1'b1;
            touch   = 1'b1;
         end
         lkvc_pkg::OP_EVICT: begin
            tgt_oh   = oldest_oh_ff;
            old_rank = IDX_W'(occ_ff - OCC_W'(1));
            touch    = 1'b1;
         end
         default: begin
            touch = 1'b0;
         end
      endcase
   end

   // memory controls
   always_comb begin
      val_rd_en   = cmd.read && (cmd.op == lkvc_pkg::OP_GET_HIT);
      key_rd_en   = cmd.read && (cmd.op == lkvc_pkg::OP_EVICT);
      val_wr_en   = cmd.commit && (cmd.op inside {lkvc_pkg::OP_SET_HIT, lkvc_pkg::OP_FILL,
                                                  lkvc_pkg::OP_EVICT});
      key_wr_en   = cmd.commit && (cmd.op inside {lkvc_pkg::OP_FILL, lkvc_pkg::OP_EVICT});
      key_wr_addr = (cmd.op == lkvc_pkg::OP_FILL) ? free_idx_ff : oldest_idx_ff;
      val_wr_addr = (cmd.op == lkvc_pkg::OP_SET_HIT) ? found_idx_ff : key_wr_addr;
   end

   // valid, recency and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.commit && touch) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_oh[i]) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && (age_all || (rank_ff[i] < old_rank))) begin
               rank_ff[i] <= rank_ff[i] + IDX_W'(1);
            end
         end
         if (age_all) begin
            valid_ff <= valid_ff | tgt_oh;
            occ_ff   <= occ_ff + OCC_W'(1);
         end
      end
   end

   // key match array
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_oh[i]) begin
               cam_key_ff[i] <= key_ff;
            end
         end
      end
   end

   lkvc_ram #(
      .WIDTH (lkvc_pkg::VALUE_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (value_ff),
      .rd_en   (val_rd_en),
      .rd_addr (found_idx_ff),
      .rd_data (val_rdata)
   );

   // copy of the keys for reading out the evicted one
   lkvc_ram #(
      .WIDTH (lkvc_pkg::KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (oldest_idx_ff),
      .rd_data (key_rdata)
   );

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff         <= (cmd.op inside {lkvc_pkg::OP_GET_HIT, lkvc_pkg::OP_SET_HIT});
         rsp_read_value_ff  <= (cmd.op == lkvc_pkg::OP_GET_HIT) ? val_rdata : '0;
         rsp_evicted_ff     <= (cmd.op == lkvc_pkg::OP_EVICT);
         rsp_evicted_key_ff <= (cmd.op == lkvc_pkg::OP_EVICT) ? key_rdata : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

/* design/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative get/set cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; busy then stays
// high through key match, memory read and table commit, and the result appears
// on the rsp_ ports with rsp_valid for one cycle. The result cannot be held off;
// a new transaction may be accepted in the same cycle as that strobe, but not
// before, since the value and key memories each have a single read port, read
// in the cycle before the commit that may overwrite them. Valid and recency
// state lives in flops, so the cache is usable straight out of reset.
// capacity_in_use (byte address 0) must be written only while busy is low;
// the block itself does not enforce this.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic signed [lkvc_pkg::KEY_W-1:0]     req_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]          req_value,
   // response channel
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic [lkvc_pkg::VALUE_W-1:0]          rsp_read_value,
   output logic                                  rsp_evicted,
   output logic signed [lkvc_pkg::KEY_W-1:0]     rsp_evicted_key,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   logic [lkvc_pkg::CAP_W-1:0] capacity_ff;
   logic                       cap_sel;
   lkvc_pkg::cmd_type          cmd;
   lkvc_pkg::status_type       status;

   // register decode on word index
   assign cap_sel = (paddr[lkvc_pkg::CSR_ADDR_W-1:2] == lkvc_pkg::CSR_IDX_CAPACITY);
   assign pready  = 1'b1;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else if (psel && penable && pwrite && pready && cap_sel) begin
         capacity_ff <= pwdata[lkvc_pkg::CAP_W-1:0];
      end
   end

   // read back
   assign prdata = cap_sel ? lkvc_pkg::CSR_DATA_W'(capacity_ff) : '0;

   lkvc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .capacity        (capacity_ff),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

endmodule

/* design/lkvc_checker.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Port-level checks on transaction timing and result consistency.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic                              rsp_hit,
   input logic [lkvc_pkg::VALUE_W-1:0]      rsp_read_value,
   input logic                              rsp_evicted,
   input logic signed [lkvc_pkg::KEY_W-1:0] rsp_evicted_key
);

   // every accepted transaction is answered with rsp_valid
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted transaction gave no result");

   // no result without a matching accepted transaction before it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without a matching transaction");

   // an eviction is a set miss: no hit and no read data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (!rsp_hit && (rsp_read_value == '0)))
      else $error("eviction reported together with a hit");

   // evicted key is zero when nothing was evicted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
      else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_read_value  (rsp_read_value),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key)
);

/* bench/tb_lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get/set transactions through the start/busy handshake, predicts
// every response with a behavioural copy of the cache, and checks each
// response strobe against the oldest prediction. Capacity is reprogrammed
// over the APB port between phases, including out-of-range values.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

   localparam int ENTRIES = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PHASES = 10;
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;
   localparam logic [lkvc_pkg::CSR_ADDR_W-1:0] CAPACITY_ADDR =
      lkvc_pkg::CSR_ADDR_W'(4 * lkvc_pkg::CSR_IDX_CAPACITY);

   typedef struct packed {
      logic                         is_set;
      logic [lkvc_pkg::KEY_W-1:0]   key;
      logic [lkvc_pkg::VALUE_W-1:0] value;
   } cache_req_type;

   typedef struct packed {
      logic                         hit;
      logic [lkvc_pkg::VALUE_W-1:0] read_value;
      logic                         evicted;
      logic [lkvc_pkg::KEY_W-1:0]   evicted_key;
   } cache_rsp_type;

   // DUT signals
   logic                              clock;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic                              req_type = REQ_GET;
   logic signed [lkvc_pkg::KEY_W-1:0] req_key = '0;
   logic [lkvc_pkg::VALUE_W-1:0]      req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_hit;
   logic [lkvc_pkg::VALUE_W-1:0]      rsp_read_value;
   logic                              rsp_evicted;
   logic signed [lkvc_pkg::KEY_W-1:0] rsp_evicted_key;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [lkvc_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [lkvc_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   logic [lkvc_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   // bench state
   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   int            send_idle_pct = 35;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   int            capacity_plan[NUM_PHASES] = '{16, 2, 0, 31, 1, 17, 8, 16, 5, 3};

   // shadow copy of the cache
   logic [lkvc_pkg::KEY_W-1:0]   shadow_key[ENTRIES];
   logic [lkvc_pkg::VALUE_W-1:0] shadow_value[ENTRIES];
   bit                           shadow_valid[ENTRIES];
   int                           shadow_age[ENTRIES];
   int                           shadow_count = 0;
   int                           shadow_capacity = int'(lkvc_pkg::CAP_RESET);

   lru_key_value_cache #(.ENTRIES(ENTRIES)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Make a slot the most recent; valid entries younger than it age by one.
   function automatic void promote_slot(int slot, int old_age);
      for (int i = 0; i < ENTRIES; i++) begin
         if (i != slot && shadow_valid[i] && shadow_age[i] < old_age)
            shadow_age[i]++;
      end
      shadow_age[slot] = 0;
   endfunction

   // Apply one transaction to the shadow cache and return its response.
   function automatic cache_rsp_type lookup_and_update(cache_req_type rq);
      cache_rsp_type rsp;
      int            found;
      int            free_slot;
      int            oldest;
      int            cap;
      rsp = '0;
      found = -1;
      free_slot = -1;
      oldest = -1;
      cap = shadow_capacity;
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_valid[i]) begin
            if (shadow_key[i] == rq.key) found = i;
            if (oldest < 0 || shadow_age[i] > shadow_age[oldest]) oldest = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (found >= 0) begin
         rsp.hit = 1'b1;
         promote_slot(found, shadow_age[found]);
         if (rq.is_set == REQ_SET)
            shadow_value[found] = rq.value;
         else
            rsp.read_value = shadow_value[found];
      end else if (rq.is_set == REQ_SET) begin
         if (shadow_count < cap && free_slot >= 0) begin
            shadow_valid[free_slot] = 1'b1;
            shadow_key[free_slot] = rq.key;
            shadow_value[free_slot] = rq.value;
            promote_slot(free_slot, ENTRIES);
            shadow_count++;
         end else if (oldest >= 0) begin
            rsp.evicted = 1'b1;
            rsp.evicted_key = shadow_key[oldest];
            shadow_key[oldest] = rq.key;
            shadow_value[oldest] = rq.value;
            promote_slot(oldest, shadow_age[oldest]);
         end
      end
      return rsp;
   endfunction

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("ERROR: %s", msg);
   endtask

   function automatic void add_req(logic is_set, logic [lkvc_pkg::KEY_W-1:0] key,
                                   logic [lkvc_pkg::VALUE_W-1:0] value);
      cache_req_type rq;
      rq.is_set = is_set;
      rq.key = key;
      rq.value = value;
      pending_reqs = {pending_reqs, rq};
   endfunction

   // Random traffic: mostly keys from a small pool sized around the capacity
   // so that hits, fills and evictions all occur, plus stray and extreme keys.
   task automatic queue_mixed_traffic(int count, int cap_raw);
      logic [lkvc_pkg::KEY_W-1:0] key_pool[$];
      int                         cap;
      int                         pick;
      logic [lkvc_pkg::KEY_W-1:0] key;
      cap = (cap_raw < 1) ? 1 : ((cap_raw > ENTRIES) ? ENTRIES : cap_raw);
      for (int i = 0; i < cap + $urandom_range(cap + 2, 1); i++)
         key_pool = {key_pool, lkvc_pkg::KEY_W'($urandom)};
      if ($urandom_range(1) == 1) key_pool = {key_pool, 32'h8000_0000};
      if ($urandom_range(1) == 1) key_pool = {key_pool, 32'h7fff_ffff};
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 80)
            key = key_pool[$urandom_range(key_pool.size() - 1)];
         else if (pick < 90)
            key = $urandom;
         else begin
            case ($urandom_range(3))
               0: key = 32'h8000_0000;
               1: key = 32'h7fff_ffff;
               2: key = '0;
               default: key = '1;
            endcase
         end
         add_req(($urandom_range(99) < 55) ? REQ_SET : REQ_GET, key,
                 lkvc_pkg::VALUE_W'($urandom));
      end
   endtask

   // Driver: presents queued transactions, predicts each one as it is accepted
   always @(posedge clock) begin : driver
      cache_req_type nxt;
      cache_req_type taken;
      cache_rsp_type pred;
      if (reset) begin
         start <= 1'b0;
         req_type <= REQ_GET;
         req_key <= '0;
         req_value <= '0;
      end else begin
         if (start && !busy) begin
            taken.is_set = req_type;
            taken.key = req_key;
            taken.value = req_value;
            pred = lookup_and_update(taken);
            expected_rsps = {expected_rsps, pred};
         end
         // free to present the next transaction
         if (!start || !busy) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               start <= 1'b1;
               req_type <= nxt.is_set;
               req_key <= nxt.key;
               req_value <= nxt.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks response strobes and runs the watchdog
   always @(posedge clock) begin : monitor
      cache_rsp_type got;
      cache_rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            got.hit = rsp_hit;
            got.read_value = rsp_read_value;
            got.evicted = rsp_evicted;
            got.evicted_key = rsp_evicted_key;
            if (expected_rsps.size() == 0) begin
               flag_mismatch($sformatf("unexpected response hit=%0b read=%h ev=%0b evkey=%h",
                                       got.hit, got.read_value, got.evicted,
                                       got.evicted_key));
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want)
                  flag_mismatch($sformatf(
                     "response hit=%0b/%0b read=%h/%h ev=%0b/%0b evkey=%h/%h (exp/act)",
                     want.hit, got.hit, want.read_value, got.read_value,
                     want.evicted, got.evicted, want.evicted_key, got.evicted_key));
            end
         end
         if ((start && !busy) || rsp_valid || (psel && penable))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired, no transaction for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Stimulus: phases of capacity settings and traffic
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = (ph < 4) ? 35 : ((ph < 7) ? 68 : 0);

         // reprogram capacity while idle, then read it back
         if (ph > 0) begin
            @(posedge clock);
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= CAPACITY_ADDR;
            pwdata <= capacity_plan[ph];
            @(posedge clock);
            penable <= 1'b1;
            @(posedge clock);
            shadow_capacity = capacity_plan[ph] & 32'h1f;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge clock);
            psel <= 1'b1;
            @(posedge clock);
            penable <= 1'b1;
            @(posedge clock);
            if (prdata !== lkvc_pkg::CSR_DATA_W'(shadow_capacity))
               flag_mismatch($sformatf("capacity readback exp=%h act=%h",
                                       lkvc_pkg::CSR_DATA_W'(shadow_capacity), prdata));
            psel <= 1'b0;
            penable <= 1'b0;
         end

         if (ph == 0) begin
            // empty cache, extreme keys and values, hits on get and set
            add_req(REQ_GET, 32'h0000_0000, 31'h7fff_ffff);
            add_req(REQ_SET, 32'h8000_0000, 31'h7fff_ffff);
            add_req(REQ_SET, 32'h7fff_ffff, 31'h0000_0000);
            add_req(REQ_SET, 32'h0000_0000, 31'h0000_0001);
            add_req(REQ_SET, 32'hffff_ffff, 31'h2aaa_aaaa);
            add_req(REQ_GET, 32'h8000_0000, 31'h0000_0000);
            add_req(REQ_GET, 32'h7fff_ffff, 31'h5555_5555);
            add_req(REQ_SET, 32'h7fff_ffff, 31'h5555_5555);
            add_req(REQ_GET, 32'h7fff_ffff, 31'h0000_0000);
            add_req(REQ_GET, 32'h1234_5678, 31'h0000_0000);
            add_req(REQ_GET, 32'hffff_ffff, 31'h0000_0000);
         end else if (ph == 1) begin
            // capacity now below occupancy: set misses evict oldest first
            add_req(REQ_SET, 32'h0000_0005, 31'h0000_0005);
            add_req(REQ_SET, 32'h0000_0006, 31'h0000_0006);
            add_req(REQ_GET, 32'h0000_0005, 31'h0000_0000);
            add_req(REQ_SET, 32'h0000_0007, 31'h7fff_0000);
            add_req(REQ_GET, 32'h8000_0000, 31'h0000_0000);
            add_req(REQ_GET, 32'h0000_0006, 31'h0000_0000);
            add_req(REQ_SET, 32'hffff_ffff, 31'h0000_ffff);
         end else begin
            queue_mixed_traffic(82, capacity_plan[ph]);
         end

         // drain: every transaction taken and answered, then settle
         while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (expected_rsps.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
